/* rtl/tfrf_pkg.sv */
// shared types, constants and the reset image of the tuner register bank
// no dependencies
`default_nettype none
package tfrf_pkg;

	localparam int REG_COUNT = 16;
	localparam int IDX_W     = $clog2(REG_COUNT);
	localparam int BYTE_W    = 8;
	localparam int PTR_W     = 8;
	localparam int MODE_W    = 3;
	localparam int WR_SLOTS  = 7;
	localparam int SLOT_W    = $clog2(WR_SLOTS);

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef byte_t bank_t [REG_COUNT];

	typedef enum logic [MODE_W-1:0] {
		MODE_START_WR = 3'd0,
		MODE_START_RD = 3'd1,
		MODE_FINISH   = 3'd2,
		MODE_NACK     = 3'd3,
		MODE_WR_BYTE  = 3'd4,
		MODE_RD_BYTE  = 3'd5
	} mode_t;

	// register roles
	localparam idx_t REG_STATUS   = 4'd0;
	localparam idx_t REG_RD_CLR   = 4'd1;
	localparam idx_t REG_FREQ_HI  = 4'd2;
	localparam idx_t REG_FREQ_LO  = 4'd3;
	localparam idx_t REG_CTRL     = 4'd4;
	localparam idx_t REG_TUNED_HI = 4'd6;
	localparam idx_t REG_TUNED_LO = 4'd7;
	localparam idx_t REG_LOCK     = 4'd9;

	localparam byte_t FREQ_HI_MASK = 8'h3F;
	localparam int    POWER_BIT    = 6;
	localparam byte_t LOCK_MASK    = 8'h08;
	localparam byte_t READY_MASK   = 8'h02;

	localparam bank_t BANK_INIT = '{
		8'h00, 8'h00, 8'h80, 8'h00, 8'h08, 8'hD2, 8'h00, 8'h00,
		8'h00, 8'hF0, 8'h00, 8'h00, 8'h40, 8'h2B, 8'h57, 8'h61
	};

	// one decoded bus event handed to the register core
	typedef struct packed {
		logic                fire;
		logic [MODE_W-1:0]   mode;
		byte_t               write_data;
	} step_t;

	// bank register that takes the n-th written byte
	function automatic idx_t slot_target(input logic [SLOT_W-1:0] slot);
		idx_t target;
		case (slot)
			3'd0:    target = 4'd1;
			3'd1:    target = 4'd2;
			3'd2:    target = 4'd3;
			3'd3:    target = 4'd4;
			3'd4:    target = 4'd5;
			3'd5:    target = 4'd10;
			default: target = 4'd11;
		endcase
		return target;
	endfunction

endpackage
`default_nettype wire

/* rtl/tfrf_in_if.sv */
// valid/ready channel carrying one bus event
// depends on tfrf_pkg
`default_nettype none
interface tfrf_in_if;
	logic                        valid;
	logic                        ready;
	logic [tfrf_pkg::MODE_W-1:0] mode;
	tfrf_pkg::byte_t             write_data;

	modport source (output valid, output mode, output write_data, input ready);
	modport sink (input valid, input mode, input write_data, output ready);
endinterface
`default_nettype wire

/* rtl/tfrf_out_if.sv */
// valid/ready channel carrying one read byte
// depends on tfrf_pkg
`default_nettype none
interface tfrf_out_if;
	logic            valid;
	logic            ready;
	tfrf_pkg::byte_t read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface
`default_nettype wire

/* rtl/i2c_fm_tuner_register_file.sv */
// a beat is held in the input register, then passes the core into the result register
// throughput: one bus event per cycle, sustained while the result side takes beats
// the result register parts the two sides, so a new event enters while a result waits
// reset: arst_n clears the pipeline and result valids, both indices and the writing flag,
// and loads the sixteen bank registers with their fixed default contents
// depends on tfrf_pkg, tfrf_in_if, tfrf_out_if and tfrf_core
`default_nettype none
module i2c_fm_tuner_register_file (
	input wire logic  clk,
	input wire logic  arst_n,
	tfrf_in_if.sink   item,
	tfrf_out_if.source result
);

	// input register: holds one bus event until the core consumes it
	logic                        valid_s1;
	logic [tfrf_pkg::MODE_W-1:0] mode_s1;
	tfrf_pkg::byte_t             data_s1;

	// result register
	logic            res_valid_q;
	tfrf_pkg::byte_t res_data_q;

	tfrf_pkg::step_t step;
	tfrf_pkg::byte_t core_rd;
	logic            advance;
	logic            take_in;

	// stage 1 moves on when the result slot is empty or being drained this cycle
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take_in    = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// event payload needs no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			mode_s1 <= item.mode;
			data_s1 <= item.write_data;
		end
	end

	// the core updates its state exactly once per event, in order
	always_comb begin
		step.fire       = advance;
		step.mode       = mode_s1;
		step.write_data = data_s1;
	end

	tfrf_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rd_byte (core_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_data_q <= core_rd;
	end

	assign result.valid     = res_valid_q;
	assign result.read_data = res_data_q;

endmodule
`default_nettype wire

/* rtl/tfrf_core.sv */
// register bank, read/write indices and writing flag with their update logic
// depends on tfrf_pkg
`default_nettype none
module tfrf_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tfrf_pkg::step_t step,
	output tfrf_pkg::byte_t      rd_byte
);

	tfrf_pkg::bank_t bank_q, bank_d;
	tfrf_pkg::ptr_t  rd_ptr_q, rd_ptr_d;
	tfrf_pkg::ptr_t  wr_ptr_q, wr_ptr_d;
	logic            wr_active_q, wr_active_d;

	always_comb begin
		bank_d      = bank_q;
		rd_ptr_d    = rd_ptr_q;
		wr_ptr_d    = wr_ptr_q;
		wr_active_d = wr_active_q;
		rd_byte     = '0;
		unique case (step.mode)
			tfrf_pkg::MODE_START_WR: begin
				wr_ptr_d    = '0;
				wr_active_d = 1'b1;
			end
			tfrf_pkg::MODE_START_RD: begin
				rd_ptr_d    = '0;
				wr_active_d = 1'b0;
			end
			tfrf_pkg::MODE_FINISH: begin
				if (wr_active_q && wr_ptr_q > 8'd1) begin
					if (bank_q[tfrf_pkg::REG_CTRL][tfrf_pkg::POWER_BIT]) begin
						bank_d[tfrf_pkg::REG_TUNED_HI] =
							bank_q[tfrf_pkg::REG_FREQ_HI] & tfrf_pkg::FREQ_HI_MASK;
						bank_d[tfrf_pkg::REG_TUNED_LO] = bank_q[tfrf_pkg::REG_FREQ_LO];
						bank_d[tfrf_pkg::REG_LOCK] =
							bank_q[tfrf_pkg::REG_LOCK] | tfrf_pkg::LOCK_MASK;
						bank_d[tfrf_pkg::REG_STATUS] =
							bank_q[tfrf_pkg::REG_STATUS] | tfrf_pkg::READY_MASK;
					end else begin
						bank_d[tfrf_pkg::REG_LOCK] =
							bank_q[tfrf_pkg::REG_LOCK] & ~tfrf_pkg::LOCK_MASK;
						bank_d[tfrf_pkg::REG_STATUS] =
							bank_q[tfrf_pkg::REG_STATUS] & ~tfrf_pkg::READY_MASK;
					end
				end
				wr_active_d = 1'b0;
			end
			tfrf_pkg::MODE_NACK: begin
				wr_active_d = 1'b0;
			end
			tfrf_pkg::MODE_WR_BYTE: begin
				if (wr_ptr_q < tfrf_pkg::PTR_W'(tfrf_pkg::WR_SLOTS))
					bank_d[tfrf_pkg::slot_target(wr_ptr_q[tfrf_pkg::SLOT_W-1:0])] =
						step.write_data;
				wr_ptr_d = wr_ptr_q + 8'd1;
			end
			tfrf_pkg::MODE_RD_BYTE: begin
				if (rd_ptr_q < tfrf_pkg::PTR_W'(tfrf_pkg::REG_COUNT))
					rd_byte = bank_q[rd_ptr_q[tfrf_pkg::IDX_W-1:0]];
				rd_ptr_d = rd_ptr_q + 8'd1;
				// clear on read for the two status bytes
				if (rd_ptr_q == 8'd0)
					bank_d[tfrf_pkg::REG_STATUS] = '0;
				else if (rd_ptr_q == 8'd1)
					bank_d[tfrf_pkg::REG_RD_CLR] = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= tfrf_pkg::BANK_INIT;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			wr_active_q <= 1'b0;
		end else if (step.fire) begin
			bank_q      <= bank_d;
			rd_ptr_q    <= rd_ptr_d;
			wr_ptr_q    <= wr_ptr_d;
			wr_active_q <= wr_active_d;
		end
	end

endmodule
`default_nettype wire

/* tb/tfrf_readback_checker.sv */
// read-byte checker for the tuner register file: watches both channels, keeps its own
// copy of the register bank and indices, predicts every read byte and compares
// depends on tfrf_pkg, tfrf_in_if and tfrf_out_if
module tfrf_readback_checker
	import tfrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tfrf_in_if          item,
	tfrf_out_if         result,
	output int unsigned fail_count,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	bank_t    bank;
	ptr_t     rd_ptr;
	ptr_t     wr_ptr;
	logic     wr_active;
	byte_t    read_bytes_due [$];
	byte_t    due;

	// one bus event against the shadow bank, returns the byte the block must send back
	function automatic byte_t apply_bus_event(input logic [MODE_W-1:0] m, input byte_t d);
		byte_t rd;
		idx_t  slot_reg;
		rd = '0;
		case (m)
			MODE_START_WR: begin
				wr_ptr    = '0;
				wr_active = 1'b1;
			end
			MODE_START_RD: begin
				rd_ptr    = '0;
				wr_active = 1'b0;
			end
			MODE_FINISH: begin
				// wrapped pointer of 0 or 1 counts as a short write
				if (wr_active && wr_ptr > 8'd1) begin
					if (bank[REG_CTRL][POWER_BIT]) begin
						bank[REG_TUNED_HI] = bank[REG_FREQ_HI] & FREQ_HI_MASK;
						bank[REG_TUNED_LO] = bank[REG_FREQ_LO];
						bank[REG_LOCK]     = bank[REG_LOCK] | LOCK_MASK;
						bank[REG_STATUS]   = bank[REG_STATUS] | READY_MASK;
					end else begin
						bank[REG_STATUS] = bank[REG_STATUS] & ~READY_MASK;
						bank[REG_LOCK]   = bank[REG_LOCK] & ~LOCK_MASK;
					end
				end
				wr_active = 1'b0;
			end
			MODE_NACK: begin
				wr_active = 1'b0;
			end
			MODE_WR_BYTE: begin
				if (wr_ptr < WR_SLOTS) begin
					case (wr_ptr[2:0])
						3'd0:    slot_reg = 4'd1;
						3'd1:    slot_reg = 4'd2;
						3'd2:    slot_reg = 4'd3;
						3'd3:    slot_reg = 4'd4;
						3'd4:    slot_reg = 4'd5;
						3'd5:    slot_reg = 4'd10;
						default: slot_reg = 4'd11;
					endcase
					bank[slot_reg] = d;
				end
				wr_ptr = wr_ptr + 8'd1;
			end
			MODE_RD_BYTE: begin
				if (rd_ptr < REG_COUNT) begin
					rd = bank[rd_ptr[IDX_W-1:0]];
				end
				// read-to-clear on the two lowest registers
				if (rd_ptr == 8'd0) begin
					bank[REG_STATUS] = '0;
				end else if (rd_ptr == 8'd1) begin
					bank[REG_RD_CLR] = '0;
				end
				rd_ptr = rd_ptr + 8'd1;
			end
			default: begin
			end
		endcase
		return rd;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank       = BANK_INIT;
			rd_ptr     = '0;
			wr_ptr     = '0;
			wr_active  = 1'b0;
			read_bytes_due.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// result first: a beat entering now cannot leave at this same edge
			if (result.valid && result.ready) begin
				if (read_bytes_due.size() == 0) begin
					fail_count++;
					$display("%0t: read_data expected none actual %02h", $time,
						result.read_data);
				end else begin
					due = read_bytes_due.pop_front();
					if (result.read_data !== due) begin
						fail_count++;
						$display("%0t: read_data expected %02h actual %02h", $time, due,
							result.read_data);
					end
				end
			end
			if (item.valid && item.ready) begin
				read_bytes_due.push_back(apply_bus_event(item.mode, item.write_data));
			end
			pending = read_bytes_due.size();
		end
	end

endmodule

/* tb/i2c_fm_tuner_register_file_tb.sv */
// top of the tuner register file bench: clock, reset, bus-event stimulus, result-side
// stalls, watchdog and verdict; checking lives in tfrf_readback_checker
// depends on tfrf_pkg, tfrf_in_if, tfrf_out_if, tfrf_readback_checker and the block
module i2c_fm_tuner_register_file_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tfrf_pkg::*;

	// the two mode codes the block must ignore
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	localparam int ITEM_TARGET  = 1000;
	localparam int IDLE_LIMIT   = 1000;   // cycles without any beat before giving up
	localparam int HOLD_CYCLES  = 48;     // long result-side hold-off
	localparam int TAIL_CYCLES  = 16;     // settle time after the last result
	localparam int LONG_PHASE_AT = 250;   // item count where the pointer-wrap phase runs

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        hold_request = 1'b0;
	logic        gaps_on = 1'b1;
	int unsigned sent = 0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned fail_count;
	int unsigned pending;

	tfrf_in_if  event_ch ();
	tfrf_out_if byte_ch ();

	i2c_fm_tuner_register_file u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (event_ch),
		.result (byte_ch)
	);

	tfrf_readback_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (event_ch),
		.result     (byte_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------------------
	// sender: drives at the falling edge, works in bursts with random gaps between
	// them; returns at the falling edge after its beat was accepted, valid still high
	// ---------------------------------------------------------------------------
	task automatic put_event(input logic [MODE_W-1:0] m, input byte_t d);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				event_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		event_ch.valid      <= 1'b1;
		event_ch.mode       <= m;
		event_ch.write_data <= d;
		@(posedge clk);
		while (!event_ch.ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// drop valid and wait for every outstanding read byte to come back
	task automatic drain_results();
		event_ch.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	// start write, n data beats with random content, then finish or nack
	task automatic write_transfer(input int unsigned n, input bit close_ok);
		put_event(MODE_START_WR, byte_t'($urandom));
		repeat (n) put_event(MODE_WR_BYTE, byte_t'($urandom));
		put_event(close_ok ? MODE_FINISH : MODE_NACK, byte_t'($urandom));
	endtask

	// start read, n read beats, then finish or nack
	task automatic read_transfer(input int unsigned n, input bit close_ok);
		put_event(MODE_START_RD, byte_t'($urandom));
		repeat (n) put_event(MODE_RD_BYTE, byte_t'($urandom));
		put_event(close_ok ? MODE_FINISH : MODE_NACK, byte_t'($urandom));
	endtask

	// ---------------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned kind;
		bit          wrap_done;
		wrap_done = 1'b0;
		event_ch.valid      <= 1'b0;
		event_ch.mode       <= MODE_START_WR;
		event_ch.write_data <= '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---
		// spare mode codes must leave everything alone
		put_event(MODE_SPARE_LO, 8'hFF);
		put_event(MODE_SPARE_HI, 8'h00);
		// full tune with the power bit set: tuned regs copy, lock and ready set
		put_event(MODE_START_WR, 8'h00);
		put_event(MODE_WR_BYTE, 8'hFF);
		put_event(MODE_WR_BYTE, 8'hFF);
		put_event(MODE_WR_BYTE, 8'h00);
		put_event(MODE_WR_BYTE, 8'h40);
		put_event(MODE_FINISH, 8'h00);
		// read back: status and register 1 clear on read, second read shows zero
		put_event(MODE_START_RD, 8'h00);
		put_event(MODE_RD_BYTE, 8'h00);
		put_event(MODE_RD_BYTE, 8'h00);
		put_event(MODE_RD_BYTE, 8'h00);
		put_event(MODE_START_RD, 8'h00);
		put_event(MODE_RD_BYTE, 8'h00);
		put_event(MODE_NACK, 8'h00);
		// one-byte write: finish must not touch the flags
		put_event(MODE_START_WR, 8'h00);
		put_event(MODE_WR_BYTE, 8'hA5);
		put_event(MODE_FINISH, 8'h00);
		// finish with no write in progress
		put_event(MODE_FINISH, 8'h00);
		// power bit clear: lock and ready go low
		put_event(MODE_START_WR, 8'h00);
		put_event(MODE_WR_BYTE, 8'h11);
		put_event(MODE_WR_BYTE, 8'h22);
		put_event(MODE_WR_BYTE, 8'h33);
		put_event(MODE_WR_BYTE, 8'h00);
		put_event(MODE_FINISH, 8'h00);

		// --- back-pressure: result side holds off while events keep coming ---
		gaps_on = 1'b0;
		hold_request = 1'b1;
		repeat (4) read_transfer(6, 1'b1);

		// --- random part ---
		while (sent < ITEM_TARGET) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				// mostly well-formed writes, some running past the seventh slot
				write_transfer($urandom_range(0, 9), $urandom_range(0, 9) != 0);
			end else if (kind < 80) begin
				// reads that often run past the last register
				read_transfer($urandom_range(0, 20), $urandom_range(0, 9) != 0);
			end else if (kind < 90) begin
				// noise: any mode code, bytes outside a transfer included
				repeat ($urandom_range(1, 4))
					put_event(MODE_W'($urandom_range(0, 7)), byte_t'($urandom));
			end else begin
				// write cut short by a read start, no finish in between
				put_event(MODE_START_WR, byte_t'($urandom));
				repeat ($urandom_range(0, 5)) put_event(MODE_WR_BYTE, byte_t'($urandom));
				read_transfer($urandom_range(0, 8), 1'b1);
			end

			// pointer wraparound, entered from a quiet block
			if (!wrap_done && sent >= LONG_PHASE_AT) begin
				drain_results();
				// 256 or 257 bytes leaves the write index at 0 or 1 (short write),
				// 258 wraps to 2 and triggers the power check
				write_transfer(256 + $urandom_range(0, 2), 1'b1);
				read_transfer(260 + $urandom_range(0, 20), 1'b1);
				wrap_done = 1'b1;
			end
		end

		// --- end of run ---
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// ---------------------------------------------------------------------------
	// receiver: ready changes at the falling edge, stall rate varies by stretch,
	// and one long hold-off when the stimulus asks for it
	// ---------------------------------------------------------------------------
	initial begin : result_sink
		int unsigned stall_pct;
		int unsigned stretch_left;
		stall_pct    = 0;
		stretch_left = 0;
		byte_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				byte_ch.ready <= 1'b0;
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(20, 120);
					case ($urandom_range(0, 3))
						0:       stall_pct = 0;    // no stalls at all
						1:       stall_pct = 20;
						2:       stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				stretch_left--;
				byte_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------------------
	// watchdog: too long without a beat on either channel ends the run
	// ---------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((event_ch.valid && event_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

/* sim.f */
rtl/tfrf_pkg.sv
rtl/tfrf_in_if.sv
rtl/tfrf_out_if.sv
rtl/tfrf_core.sv
rtl/i2c_fm_tuner_register_file.sv
tb/tfrf_readback_checker.sv
tb/i2c_fm_tuner_register_file_tb.sv
